FILE: design/ths_pkg.sv
// Package with the constants, payload types and operation codes of the terrain height sampler.
`timescale 1ns / 1ps

package ths_pkg;

  localparam int unsigned ChunkRow         = 16;
  localparam int unsigned TilesPerChunkRow = 4;
  localparam int unsigned TilePixelWidth   = 512;
  localparam int unsigned FracBits         = 8;

  localparam int unsigned PosW       = 24;
  localparam int unsigned CornerW    = 16;
  localparam int unsigned HeightW    = 24;
  localparam int unsigned StoreDepth = 4096;
  localparam int unsigned StoreAw    = $clog2(StoreDepth);
  localparam int unsigned TileW      = 4 * CornerW;

  localparam int unsigned MapPixels     = ChunkRow * TilesPerChunkRow * TilePixelWidth;
  localparam int unsigned TilesPerChunk = TilesPerChunkRow * TilesPerChunkRow;
  localparam int unsigned TileSpan      = TilePixelWidth << FracBits;
  localparam int unsigned PixW          = PosW - 1 - FracBits;
  localparam int unsigned FxW           = (FracBits > 0) ? FracBits : 1;
  localparam int unsigned AccW          = CornerW + 3 + FxW;
  localparam int unsigned DiffW         = AccW + 1;
  localparam int unsigned ProdW         = DiffW + FxW + 1;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef struct packed {
    op_e                        op;
    logic signed [PosW-1:0]     pos_x;
    logic signed [PosW-1:0]     pos_y;
    logic [StoreAw-1:0]         tile_address;
    logic signed [CornerW-1:0]  corner_nw;
    logic signed [CornerW-1:0]  corner_ne;
    logic signed [CornerW-1:0]  corner_sw;
    logic signed [CornerW-1:0]  corner_se;
  } req_t;

  typedef struct packed {
    logic signed [HeightW-1:0] height;
    logic                      valid_res;
  } res_t;

endpackage

FILE: design/ths_ram.sv
// Generic single-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps

module ths_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/terrain_height_sampler_core.sv
// Top level of the terrain height sampler: tile store and bilinear interpolation pipeline.
//
//   Channel   Direction  Handshake                 Payload
//   request   in         start high, busy low      req_i (req_t)
//   result    out        res_strobe_o, one cycle   res_o (res_t)
//
// One item is taken every cycle; busy stays low.
// A query's result passes through the s1, s2, s3 and result registers to res_o; a write gives none.
// The tile store is one single-port RAM; the read at the query stage and the write
// of a tile never meet in one cycle, and a write is visible to the next item.
// Reset clears the pipeline valid flags only; the store has no clearing pass.
// The receiver cannot stall, so nothing holds the pipeline.
`timescale 1ns / 1ps

module terrain_height_sampler_core
  import ths_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic res_strobe_o,
  output res_t res_o
);

  logic                accept;
  logic [PixW-1:0]     pix_x;
  logic [PixW-1:0]     pix_y;
  logic [PixW-1:0]     tile_x;
  logic [PixW-1:0]     tile_y;
  logic [PosW-2:0]     off_x;
  logic [PosW-2:0]     off_y;
  logic [StoreAw-1:0]  addr_full;
  logic                in_range;
  logic [StoreAw-1:0]  ram_addr;
  logic [TileW-1:0]    ram_rdata;

  logic                s1_vld_q;
  logic                s1_rng_q;
  logic [FxW-1:0]      s1_fx_q;
  logic [FxW-1:0]      s1_fy_q;

  logic                s2_vld_q;
  logic                s2_rng_q;
  logic [FxW-1:0]      s2_fy_q;
  logic signed [AccW-1:0] s2_a_q, s2_a_d;
  logic signed [AccW-1:0] s2_b_q, s2_b_d;

  logic                s3_vld_q;
  logic                s3_rng_q;
  logic signed [AccW-1:0]  s3_a_q;
  logic signed [ProdW-1:0] s3_p_q, s3_p_d;

  logic                res_strobe_q;
  res_t                res_q, res_d;

  logic signed [CornerW-1:0] c_nw, c_ne, c_sw, c_se;
  logic signed [CornerW:0]   dx_n, dx_s;
  logic signed [FxW:0]       fx_s, fy_s;
  logic signed [DiffW-1:0]   diff_ba;
  logic signed [ProdW-1:0]   z;

  localparam logic signed [ProdW-1:0] ZMax = ProdW'((1 <<< (HeightW - 1)) - 1);
  localparam logic signed [ProdW-1:0] ZMin = -ProdW'(1 <<< (HeightW - 1));

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    pix_x     = req_i.pos_x[PosW-2:FracBits];
    pix_y     = req_i.pos_y[PosW-2:FracBits];
    in_range  = !req_i.pos_x[PosW-1] && !req_i.pos_y[PosW-1] &&
                (32'(pix_x) < MapPixels) && (32'(pix_y) < MapPixels);
    tile_x    = PixW'(pix_x / TilePixelWidth);
    tile_y    = PixW'(pix_y / TilePixelWidth);
    off_x     = (PosW-1)'(req_i.pos_x[PosW-2:0] % TileSpan);
    off_y     = (PosW-1)'(req_i.pos_y[PosW-2:0] % TileSpan);
    addr_full = StoreAw'((tile_x / TilesPerChunkRow + (tile_y / TilesPerChunkRow) * ChunkRow) *
                         TilesPerChunk + tile_x % TilesPerChunkRow +
                         (tile_y % TilesPerChunkRow) * TilesPerChunkRow);
    ram_addr  = (req_i.op == OP_WRITE) ? req_i.tile_address : addr_full;
  end

  ths_ram #(
    .Width(TileW),
    .Depth(StoreDepth)
  ) u_store (
    .clk_i  (clk_i),
    .en_i   (accept),
    .we_i   (req_i.op == OP_WRITE),
    .addr_i (ram_addr),
    .wdata_i({req_i.corner_se, req_i.corner_sw, req_i.corner_ne, req_i.corner_nw}),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    c_nw   = ram_rdata[CornerW-1:0];
    c_ne   = ram_rdata[2*CornerW-1:CornerW];
    c_sw   = ram_rdata[3*CornerW-1:2*CornerW];
    c_se   = ram_rdata[4*CornerW-1:3*CornerW];
    dx_n   = (CornerW+1)'(c_ne) - (CornerW+1)'(c_nw);
    dx_s   = (CornerW+1)'(c_se) - (CornerW+1)'(c_sw);
    fx_s   = signed'({1'b0, s1_fx_q});
    s2_a_d = (AccW'(c_nw) <<< FracBits) + AccW'(dx_n) * AccW'(fx_s);
    s2_b_d = (AccW'(c_sw) <<< FracBits) + AccW'(dx_s) * AccW'(fx_s);
  end

  always_comb begin
    fy_s    = signed'({1'b0, s2_fy_q});
    diff_ba = DiffW'(s2_b_q) - DiffW'(s2_a_q);
    s3_p_d  = ProdW'(diff_ba) * ProdW'(fy_s);
  end

  always_comb begin
    z = ProdW'(s3_a_q) + (s3_p_q >>> FracBits);
    res_d.valid_res = s3_rng_q;
    priority if (!s3_rng_q) begin
      res_d.height = '0;
    end else if (z > ZMax) begin
      res_d.height = ZMax[HeightW-1:0];
    end else if (z < ZMin) begin
      res_d.height = ZMin[HeightW-1:0];
    end else begin
      res_d.height = z[HeightW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q     <= 1'b0;
      s2_vld_q     <= 1'b0;
      s3_vld_q     <= 1'b0;
      res_strobe_q <= 1'b0;
    end else begin
      s1_vld_q     <= accept && (req_i.op == OP_QUERY);
      s2_vld_q     <= s1_vld_q;
      s3_vld_q     <= s2_vld_q;
      res_strobe_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_rng_q <= in_range;
    s1_fx_q  <= FxW'(off_x / TilePixelWidth);
    s1_fy_q  <= FxW'(off_y / TilePixelWidth);
    s2_rng_q <= s1_rng_q;
    s2_fy_q  <= s1_fy_q;
    s2_a_q   <= s2_a_d;
    s2_b_q   <= s2_b_d;
    s3_rng_q <= s2_rng_q;
    s3_a_q   <= s2_a_q;
    s3_p_q   <= s3_p_d;
    res_q    <= res_d;
  end

  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

  a_query_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.op == OP_QUERY) |-> ##4 res_strobe_o)
    else $error("Accepted query produced no result four cycles later.");

  a_result_has_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> $past(start && !busy && req_i.op == OP_QUERY, 4))
    else $error("Result strobe without a matching query transfer.");

  a_invalid_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !res_o.valid_res) |-> (res_o.height == '0))
    else $error("Out-of-range result carries a nonzero height.");

endmodule
